### sv/tksel_pkg.sv
// Shared types and constants of the top-k score selector.
// Holds the controller state enum and the command/status structs between
// the controller and the datapath. No dependencies.
`default_nettype none

package tksel_pkg;

  localparam int KEEP_MAX_DEF   = 64;
  localparam int INDEX_BITS_DEF = 16;

  localparam int SCORE_W     = 32;
  localparam int IDX_FIELD_W = 16;
  localparam int KEEP_W      = 7;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  // request command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_FIRST,
    ST_INS_SCAN,
    ST_INS_LAST,
    ST_REP_FIRST,
    ST_REP_MIN,
    ST_REP_SCAN,
    ST_REP_LAST,
    ST_DR_FIRST,
    ST_DR_EMIT
  } state_t;

  // store write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_DATA,
    WR_NEW
  } wr_op_t;

  // store write address source
  typedef enum logic [1:0] {
    WA_UP,
    WA_DOWN,
    WA_ZERO,
    WA_TOP
  } wa_sel_t;

  typedef struct packed {
    logic    load;          // latch request, init pointer
    logic    ptr_from_top;  // pointer starts at held-1, else at 0
    logic    rd_en;         // read store at pointer, step pointer
    logic    ptr_up;        // step direction
    wr_op_t  wr_op;
    wa_sel_t wa_sel;
    logic    held_inc;
    logic    held_clr;
    logic    emit;          // register read entry as a result
  } tksel_cmd_t;

  typedef struct packed {
    logic held_zero;
    logic full;
    logic gt;       // read entry score > new score
    logic lt;       // read entry score < new score
    logic rd_zero;  // read entry is slot 0
    logic rd_top;   // read entry is the highest held slot
  } tksel_stat_t;

endpackage

`default_nettype wire

### sv/tksel_ctrl.sv
// Controller of the top-k score selector: sequences insert, replace and
// drain scans over the sorted store. Depends on tksel_pkg.
`default_nettype none

module tksel_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_command,
  input  tksel_pkg::tksel_stat_t stat,
  output tksel_pkg::tksel_cmd_t  cmd,
  output logic                  busy
);
  import tksel_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_DRAIN) begin
            state_nxt = stat.held_zero ? ST_IDLE : ST_DR_FIRST;
          end else if (stat.full) begin
            state_nxt = ST_REP_FIRST;
          end else begin
            state_nxt = stat.held_zero ? ST_INS_LAST : ST_INS_FIRST;
          end
        end
      end
      ST_INS_FIRST: state_nxt = ST_INS_SCAN;
      ST_INS_SCAN: begin
        if (!stat.gt) begin
          state_nxt = ST_IDLE;
        end else if (stat.rd_zero) begin
          state_nxt = ST_INS_LAST;
        end
      end
      ST_INS_LAST:  state_nxt = ST_IDLE;
      ST_REP_FIRST: state_nxt = ST_REP_MIN;
      ST_REP_MIN: begin
        if (!stat.lt || stat.rd_top) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_REP_SCAN;
        end
      end
      ST_REP_SCAN: begin
        if (stat.gt) begin
          state_nxt = ST_IDLE;
        end else if (stat.rd_top) begin
          state_nxt = ST_REP_LAST;
        end
      end
      ST_REP_LAST: state_nxt = ST_IDLE;
      ST_DR_FIRST: state_nxt = ST_DR_EMIT;
      ST_DR_EMIT: begin
        if (stat.rd_top) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '{load: 1'b0, ptr_from_top: 1'b0, rd_en: 1'b0, ptr_up: 1'b0,
            wr_op: WR_NONE, wa_sel: WA_UP, held_inc: 1'b0, held_clr: 1'b0,
            emit: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load         = 1'b1;
          cmd.ptr_from_top = (in_command == CMD_OFFER) && !stat.full;
        end
      end
      ST_INS_FIRST: begin
        cmd.rd_en = 1'b1;
      end
      ST_INS_SCAN: begin
        cmd.wa_sel = WA_UP;
        if (stat.gt) begin
          cmd.wr_op = WR_DATA;
          cmd.rd_en = !stat.rd_zero;
        end else begin
          cmd.wr_op    = WR_NEW;
          cmd.held_inc = 1'b1;
        end
      end
      ST_INS_LAST: begin
        cmd.wr_op    = WR_NEW;
        cmd.wa_sel   = WA_ZERO;
        cmd.held_inc = 1'b1;
      end
      ST_REP_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.ptr_up = 1'b1;
      end
      ST_REP_MIN: begin
        if (stat.lt) begin
          if (stat.rd_top) begin
            cmd.wr_op  = WR_NEW;
            cmd.wa_sel = WA_ZERO;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_up = 1'b1;
          end
        end
      end
      ST_REP_SCAN: begin
        cmd.wa_sel = WA_DOWN;
        if (!stat.gt) begin
          cmd.wr_op  = WR_DATA;
          cmd.rd_en  = !stat.rd_top;
          cmd.ptr_up = 1'b1;
        end else begin
          cmd.wr_op = WR_NEW;
        end
      end
      ST_REP_LAST: begin
        cmd.wr_op  = WR_NEW;
        cmd.wa_sel = WA_TOP;
      end
      ST_DR_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.ptr_up = 1'b1;
      end
      ST_DR_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.held_clr = stat.rd_top;
        cmd.rd_en    = !stat.rd_top;
        cmd.ptr_up   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/tksel_dp.sv
// Datapath of the top-k score selector: sorted entry store, scan pointer,
// held count, keep_count register and result registers. Depends on tksel_pkg.
`default_nettype none

module tksel_dp #(
  parameter int KEEP_MAX   = tksel_pkg::KEEP_MAX_DEF,
  parameter int INDEX_BITS = tksel_pkg::INDEX_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic signed [tksel_pkg::SCORE_W-1:0]      in_score,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0]  in_first_index,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0]  in_second_index,
  input  logic                                      in_is_main_effect,
  input  logic                                      cfg_we,
  input  logic        [tksel_pkg::KEEP_W-1:0]       cfg_wdata,
  input  tksel_pkg::tksel_cmd_t                     cmd,
  output tksel_pkg::tksel_stat_t                    stat,
  output logic                                      out_valid,
  output logic        [tksel_pkg::IDX_FIELD_W-1:0]  out_first,
  output logic        [tksel_pkg::IDX_FIELD_W-1:0]  out_second,
  output logic signed [tksel_pkg::SCORE_W-1:0]      out_score,
  output logic                                      out_last
);
  import tksel_pkg::*;

  localparam int ADDR_W  = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
  localparam int CNT_W   = $clog2(KEEP_MAX + 1);
  localparam int IDX_W   = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
  localparam int ENTRY_W = SCORE_W + 2 * IDX_W;

  // entry layout: {score, first, second}
  logic [ENTRY_W-1:0] mem [KEEP_MAX];

  logic [ENTRY_W-1:0] rdata_r;
  logic [ENTRY_W-1:0] new_r;
  logic [ADDR_W-1:0]  rd_idx_r;
  logic [ADDR_W-1:0]  ptr_r;
  logic [CNT_W-1:0]   held_r;
  logic [KEEP_W-1:0]  keep_r;

  logic                      out_valid_r;
  logic                      out_last_r;
  logic [IDX_FIELD_W-1:0]    out_first_r;
  logic [IDX_FIELD_W-1:0]    out_second_r;
  logic signed [SCORE_W-1:0] out_score_r;

  logic [CNT_W-1:0]   keep_eff;
  logic [ADDR_W-1:0]  top_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic signed [SCORE_W-1:0] rd_score;
  logic signed [SCORE_W-1:0] new_score;
  logic [IDX_W-1:0]   new_first;

  // keep_count zero acts as one, above the store depth saturates
  always_comb begin
    if (keep_r == '0) begin
      keep_eff = CNT_W'(1);
    end else if (keep_r > KEEP_W'(KEEP_MAX)) begin
      keep_eff = CNT_W'(KEEP_MAX);
    end else begin
      keep_eff = CNT_W'(keep_r);
    end
  end

  assign top_addr  = ADDR_W'(held_r - CNT_W'(1));
  assign rd_score  = rdata_r[ENTRY_W-1 -: SCORE_W];
  assign new_score = new_r[ENTRY_W-1 -: SCORE_W];
  assign new_first = in_is_main_effect ? '0 : in_first_index[IDX_W-1:0];

  assign stat.held_zero = (held_r == '0);
  assign stat.full      = (held_r >= keep_eff);
  assign stat.gt        = (rd_score > new_score);
  assign stat.lt        = (rd_score < new_score);
  assign stat.rd_zero   = (rd_idx_r == '0);
  assign stat.rd_top    = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == held_r);

  always_comb begin
    case (cmd.wa_sel)
      WA_UP:   wr_addr = rd_idx_r + ADDR_W'(1);
      WA_DOWN: wr_addr = rd_idx_r - ADDR_W'(1);
      WA_ZERO: wr_addr = '0;
      WA_TOP:  wr_addr = top_addr;
      default: wr_addr = '0;
    endcase
  end

  assign wr_data = (cmd.wr_op == WR_DATA) ? rdata_r : new_r;

  // entry store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_op != WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r  <= mem[ptr_r];
      rd_idx_r <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_r <= {in_score, new_first, in_second_index[IDX_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      held_r <= '0;
      keep_r <= KEEP_RESET;
    end else begin
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
      if (cmd.load) begin
        ptr_r <= cmd.ptr_from_top ? top_addr : '0;
      end else if (cmd.rd_en) begin
        ptr_r <= cmd.ptr_up ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
      end
      if (cmd.held_clr) begin
        held_r <= '0;
      end else if (cmd.held_inc) begin
        held_r <= held_r + CNT_W'(1);
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_score_r  <= rd_score;
      out_first_r  <= IDX_FIELD_W'(rdata_r[2*IDX_W-1 -: IDX_W]);
      out_second_r <= IDX_FIELD_W'(rdata_r[IDX_W-1:0]);
      out_last_r   <= stat.rd_top;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_score  = out_score_r;
  assign out_last   = out_last_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(KEEP_MAX))
    else $error("held count above store depth");

  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.held_inc |-> (held_r < keep_eff))
    else $error("insert into a full store");

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.wr_op != WR_NONE) |-> (wr_addr != ptr_r))
    else $error("store read and write hit the same slot");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result after the final drain entry");

endmodule

`default_nettype wire

### sv/top_k_score_selector.sv
// Top level of the top-k score selector: controller plus datapath.
// Depends on tksel_pkg, tksel_ctrl and tksel_dp.
// Offer: the scan moves one entry per cycle through the store, which has one
//   read port and one write port.
// Drain of h entries: h results, one per cycle; an empty drain gives no
//   result and leaves busy low.
// Results cannot be stalled. Reset (sync, active low) empties the store and
// sets keep_count to 64; store contents are not cleared.
`default_nettype none

module top_k_score_selector #(
  parameter int KEEP_MAX   = tksel_pkg::KEEP_MAX_DEF,
  parameter int INDEX_BITS = tksel_pkg::INDEX_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // request channel
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      in_command,
  input  logic signed [tksel_pkg::SCORE_W-1:0]      in_score,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0]  in_first_index,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0]  in_second_index,
  input  logic                                      in_is_main_effect,
  // keep_count register
  input  logic                                      cfg_we,
  input  logic        [tksel_pkg::KEEP_W-1:0]       cfg_wdata,
  // results, one strobe per entry
  output logic                                      out_valid,
  output logic        [tksel_pkg::IDX_FIELD_W-1:0]  out_first,
  output logic        [tksel_pkg::IDX_FIELD_W-1:0]  out_second,
  output logic signed [tksel_pkg::SCORE_W-1:0]      out_score,
  output logic                                      out_last
);
  import tksel_pkg::*;

  // The store is kept sorted by score, ascending, equal scores in arrival
  // order. An insert scans down from the top, shifting larger entries up one
  // slot until the new entry's place is found. A replace (store full) first
  // checks slot 0, then scans up, shifting entries not above the new score
  // down one slot so the minimum drops out. A drain reads slots in order.
  tksel_cmd_t  cmd;
  tksel_stat_t stat;

  tksel_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  tksel_dp #(
    .KEEP_MAX   (KEEP_MAX),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_score          (in_score),
    .in_first_index    (in_first_index),
    .in_second_index   (in_second_index),
    .in_is_main_effect (in_is_main_effect),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_first         (out_first),
    .out_second        (out_second),
    .out_score         (out_score),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

### dv/tksel_checker.sv
// Scoreboard for the top-k score selector: tracks the keep_count register
// and the held candidates, predicts every drain and checks the result stream.
// Depends on tksel_pkg for widths, command codes and the keep_count reset.

module tksel_checker (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic                                     busy,
  input  logic                                     in_command,
  input  logic signed [tksel_pkg::SCORE_W-1:0]     in_score,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0] in_first_index,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0] in_second_index,
  input  logic                                     in_is_main_effect,
  input  logic                                     cfg_we,
  input  logic        [tksel_pkg::KEEP_W-1:0]      cfg_wdata,
  input  logic                                     out_valid,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0] out_first,
  input  logic        [tksel_pkg::IDX_FIELD_W-1:0] out_second,
  input  logic signed [tksel_pkg::SCORE_W-1:0]     out_score,
  input  logic                                     out_last,
  output int                                       errors,
  output int                                       outstanding,
  output int                                       results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tksel_pkg::*;

  typedef struct packed {
    logic signed [SCORE_W-1:0]     score;
    logic        [IDX_FIELD_W-1:0] first;
    logic        [IDX_FIELD_W-1:0] second;
  } candidate_t;

  typedef struct {
    logic        [IDX_FIELD_W-1:0] first;
    logic        [IDX_FIELD_W-1:0] second;
    logic signed [SCORE_W-1:0]     score;
    logic                          last;
  } drained_entry_t;

  // ascending by score, ties in arrival order
  candidate_t     ranked[KEEP_MAX_DEF];
  int             held_n;
  logic [KEEP_W-1:0] keep_reg;
  drained_entry_t awaited[$];
  int             err_count;
  int             checked;

  task automatic flag_field(input string name, input logic [SCORE_W-1:0] exp_v,
                            input logic [SCORE_W-1:0] got_v);
    if (exp_v !== got_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, exp_v,
               got_v);
    end
  endtask

  task automatic place_offer(input candidate_t cand);
    int slot;
    int cap;
    cap = (keep_reg == 0) ? 1 : (keep_reg > KEEP_MAX_DEF) ? KEEP_MAX_DEF : int'(keep_reg);
    slot = 0;
    while (slot < held_n && $signed(ranked[slot].score) <= $signed(cand.score))
      slot++;
    if (held_n < cap) begin
      for (int i = held_n; i > slot; i--)
        ranked[i] = ranked[i-1];
      ranked[slot] = cand;
      held_n++;
    end else if (held_n > 0 && $signed(cand.score) > $signed(ranked[0].score)) begin
      // evict the minimum, slide the lower part down by one
      for (int i = 0; i + 1 < slot; i++)
        ranked[i] = ranked[i+1];
      ranked[slot-1] = cand;
    end
  endtask

  task automatic queue_drain();
    drained_entry_t d;
    for (int i = 0; i < held_n; i++) begin
      d.first  = ranked[i].first;
      d.second = ranked[i].second;
      d.score  = ranked[i].score;
      d.last   = (i == held_n - 1);
      awaited.push_back(d);
    end
    held_n = 0;
  endtask

  always @(posedge clk) begin
    candidate_t     cand;
    drained_entry_t want;
    if (!rst_n) begin
      held_n   = 0;
      keep_reg = KEEP_RESET;
      awaited.delete();
    end else begin
      if (out_valid) begin
        checked++;
        if (awaited.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual score 0x%08h",
                   $time, out_score);
        end else begin
          want = awaited.pop_front();
          flag_field("out_first", want.first, out_first);
          flag_field("out_second", want.second, out_second);
          flag_field("out_score", want.score, out_score);
          flag_field("out_last", want.last, out_last);
        end
      end
      if (cfg_we)
        keep_reg = cfg_wdata;
      if (start && !busy) begin
        if (in_command == CMD_DRAIN) begin
          queue_drain();
        end else begin
          cand.score  = in_score;
          cand.first  = in_is_main_effect ? '0 : in_first_index;
          cand.second = in_second_index;
          place_offer(cand);
        end
      end
    end
    errors       <= err_count;
    outstanding  <= awaited.size();
    results_seen <= checked;
  end

endmodule

### dv/tb.sv
// Testbench top for the top-k score selector: clock, reset, request and
// keep_count stimulus, watchdog and verdict. Checking lives in tksel_checker.
// Depends on tksel_pkg, tksel_checker and the top_k_score_selector RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tksel_pkg::*;

  // Longest stretch without any accepted request, result or register write:
  // a register write waits out a settle window plus an offer into a full
  // store, and the end waits out another settle window, with ample margin.
  localparam int WATCHDOG_LIMIT = 2000;
  // Offers produce no result, so before a register write or the verdict we
  // give the block at least its worst offer time to settle.
  localparam int SETTLE_CYCLES  = 100;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_command = CMD_OFFER;
  logic signed [SCORE_W-1:0]     in_score = '0;
  logic        [IDX_FIELD_W-1:0] in_first_index = '0;
  logic        [IDX_FIELD_W-1:0] in_second_index = '0;
  logic                          in_is_main_effect = 1'b0;
  logic                          cfg_we = 1'b0;
  logic        [KEEP_W-1:0]      cfg_wdata = '0;
  logic                          out_valid;
  logic        [IDX_FIELD_W-1:0] out_first;
  logic        [IDX_FIELD_W-1:0] out_second;
  logic signed [SCORE_W-1:0]     out_score;
  logic                          out_last;

  int errors;
  int outstanding;
  int results_seen;
  int quiet_cycles = 0;
  int requests_sent = 0;
  int drains_sent = 0;
  int keep_writes = 0;
  bit gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  top_k_score_selector u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_score          (in_score),
    .in_first_index    (in_first_index),
    .in_second_index   (in_second_index),
    .in_is_main_effect (in_is_main_effect),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_first         (out_first),
    .out_second        (out_second),
    .out_score         (out_score),
    .out_last          (out_last)
  );

  tksel_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_score          (in_score),
    .in_first_index    (in_first_index),
    .in_second_index   (in_second_index),
    .in_is_main_effect (in_is_main_effect),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_first         (out_first),
    .out_second        (out_second),
    .out_score         (out_score),
    .out_last          (out_last),
    .errors            (errors),
    .outstanding       (outstanding),
    .results_seen      (results_seen)
  );

  // Present one request and hold it until the edge where busy is low.
  // start stays high on return so back-to-back requests never toggle it
  // within one time step; a random gap lowers it first.
  task automatic issue_request(input logic cmd, input logic signed [SCORE_W-1:0] sc,
                               input logic [IDX_FIELD_W-1:0] fi,
                               input logic [IDX_FIELD_W-1:0] se, input logic me);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start             <= 1'b1;
    in_command        <= cmd;
    in_score          <= sc;
    in_first_index    <= fi;
    in_second_index   <= se;
    in_is_main_effect <= me;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (cmd == CMD_DRAIN)
      drains_sent++;
  endtask

  // keep_count is only written with the block idle: all drained entries
  // back, then a settle window so a trailing offer has finished its scan.
  task automatic write_keep(input logic [KEEP_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_writes++;
  endtask

  // Scores lean on a small pool so ties and equal-to-minimum offers are
  // common; the rest are full-range or the signed extremes.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int step;
    case ($urandom_range(0, 3))
      0: begin
        step = $urandom_range(0, 6) - 3;
        return SCORE_W'(step <<< 16);
      end
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7FFF_FFFF;
          3: return 32'sh7FFF_FFFE;
          4: return -32'sd1;
          default: return '0;
        endcase
      end
      default: begin
        step = $urandom_range(0, 7) - 4;
        return SCORE_W'(step);
      end
    endcase
  endfunction

  // Index fields are passed through, zero and all-ones included.
  function automatic logic [IDX_FIELD_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return IDX_FIELD_W'($urandom);
    endcase
  endfunction

  // One keep_count setting, then a burst of offers with drains mixed in.
  // drain_odds of 0 means no random drains, so the store can fill and start
  // evicting; ending without a drain leaves entries held for the next
  // setting, which is how keep_count gets lowered below the held count.
  task automatic run_phase(input logic [KEEP_W-1:0] keep, input int n_items,
                           input int drain_odds, input bit drain_at_end);
    bit do_drain;
    write_keep(keep);
    for (int k = 0; k < n_items; k++) begin
      do_drain = (drain_at_end && k == n_items - 1) ||
                 (drain_odds != 0 && $urandom_range(1, drain_odds) == 1);
      issue_request(do_drain ? CMD_DRAIN : CMD_OFFER, pick_score(), pick_index(),
                    pick_index(), $urandom_range(0, 3) == 0);
    end
  endtask

  // Watchdog: counts cycles in which nothing moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, block stopped making progress", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: keep_count at its reset value of 64 ----
    // drain of an empty store gives nothing
    issue_request(CMD_DRAIN, '0, '0, '0, 1'b0);
    // signed extremes, all-ones and zero indices, a main effect whose
    // first index must come back as 0, and a tie on score 0
    issue_request(CMD_OFFER, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    issue_request(CMD_OFFER, 32'sh8000_0000, 16'h0000, 16'h0000, 1'b0);
    issue_request(CMD_OFFER, 32'sh0000_0000, 16'h1234, 16'h0042, 1'b1);
    issue_request(CMD_OFFER, 32'sh0000_0000, 16'h0007, 16'h0008, 1'b0);
    // partly filled store: only the four held entries drain
    issue_request(CMD_DRAIN, '0, '0, '0, 1'b0);

    // ---- keep 2: fill, then offers at and above the minimum ----
    write_keep(7'd2);
    issue_request(CMD_OFFER, -32'sd65536, 16'd1, 16'd2, 1'b0);
    issue_request(CMD_OFFER, 32'sh0005_0000, 16'd3, 16'd4, 1'b0);
    // equal to the minimum: must not replace it
    issue_request(CMD_OFFER, -32'sd65536, 16'd5, 16'd6, 1'b0);
    issue_request(CMD_OFFER, 32'sh0003_0000, 16'd7, 16'd8, 1'b0);
    // main effect into a full store, strictly greater: replaces
    issue_request(CMD_OFFER, 32'sh0007_0000, 16'd9, 16'd10, 1'b1);
    issue_request(CMD_DRAIN, '0, '0, '0, 1'b0);

    // ---- keep 0 behaves as keep 1 ----
    write_keep(7'd0);
    issue_request(CMD_OFFER, 32'sh000A_0000, 16'd11, 16'd12, 1'b0);
    issue_request(CMD_OFFER, 32'sh000A_0000, 16'd13, 16'd14, 1'b0);
    issue_request(CMD_OFFER, 32'sh000B_0000, 16'd15, 16'd16, 1'b0);
    issue_request(CMD_DRAIN, '0, '0, '0, 1'b0);

    // ---- keep 4 filled, then lowered to 2 with four entries held ----
    write_keep(7'd4);
    issue_request(CMD_OFFER, 32'sh0001_0000, 16'd21, 16'd22, 1'b0);
    issue_request(CMD_OFFER, 32'sh0002_0000, 16'd23, 16'd24, 1'b0);
    issue_request(CMD_OFFER, 32'sh0003_0000, 16'd25, 16'd26, 1'b0);
    issue_request(CMD_OFFER, 32'sh0004_0000, 16'd27, 16'd28, 1'b1);
    write_keep(7'd2);
    // store counts as full: below the minimum is dropped, above replaces
    issue_request(CMD_OFFER, 32'sh0000_0000, 16'd29, 16'd30, 1'b0);
    issue_request(CMD_OFFER, 32'sh0009_0000, 16'd31, 16'd32, 1'b0);
    issue_request(CMD_DRAIN, '0, '0, '0, 1'b0);
    issue_request(CMD_DRAIN, '0, '0, '0, 1'b0);

    // ---- random phases ----
    // 127 saturates to 64: fill the whole store, evict, drain 64 entries
    run_phase(7'd127, 75, 0, 1'b1);
    run_phase(7'd6, 18, 5, 1'b0);
    run_phase(7'd1, 10, 4, 1'b0);
    run_phase(7'd0, 10, 4, 1'b0);
    run_phase(KEEP_W'($urandom_range(2, 16)), 18, 6, 1'b0);
    run_phase(7'd3, 14, 6, 1'b0);
    run_phase(7'd64, 14, 5, 1'b0);
    // closing stretch runs without gaps
    gaps_on = 1'b0;
    run_phase(KEEP_W'($urandom_range(1, 64)), 18, 5, 1'b1);

    // wind down: every drained entry back, then a settle window
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d drains) over %0d keep_count settings,",
             requests_sent, drains_sent, keep_writes);
    $display("with %0d drained entries checked against the prediction.", results_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
